[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the cubic segment evaluator.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CSE_ASSERT(lbl, prop, msg)
`define CSE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/cse_pkg.sv]
// Shared types and constants for the cubic segment evaluator.
// No dependencies.
package cse_pkg;

  typedef enum logic [1:0] {
    BASIS_BEZIER  = 2'd0,
    BASIS_BSPLINE = 2'd1,
    BASIS_CATMULL = 2'd2
  } basis_t;

  // control that travels with each item down the pipeline
  typedef struct packed {
    logic   valid;
    logic   neg;
    basis_t basis;
  } ctl_t;

  // stages per Horner step: magnitude, multiply, combine
  localparam int STEP_LAT = 3;

  // divide by 3, one 8-bit digit per stage
  localparam int DIGIT_W   = 8;
  localparam int REM_W     = 2;
  localparam int DV_W      = DIGIT_W + REM_W;
  localparam int DPROD_W   = 2 * DV_W;
  localparam int DIV3_SHIFT = 11;
  // ceil(2^11 / 3): exact floor(v/3) for every v below 2^11
  localparam logic [DV_W-1:0] DIV3_RECIP = DV_W'(683);

endpackage

[rtl/cse_horner_step.sv]
// One Horner step: acc_o = R(acc_i * t) + k_i, in three register stages.
// Depends on cse_pkg.
module cse_horner_step import cse_pkg::*; #(
  parameter int AW = 38,
  parameter int TF = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_t                 ctl_i,
  input  logic signed [AW-1:0] acc_i,
  input  logic [TF:0]          t_i,
  input  logic signed [AW-1:0] k_i,
  output ctl_t                 ctl_o,
  output logic signed [AW-1:0] acc_o
);

  localparam int MW  = AW - 1;
  localparam int HW  = MW - TF;
  localparam int TW  = TF + 1;
  localparam int PLW = TF + TW;
  localparam int PHW = HW + TW;
  localparam logic [PLW-1:0] T_HALF = PLW'(1) << (TF - 1);

  // stage A: sign and magnitude
  ctl_t                 ctl_a_r;
  logic                 neg_a_r;
  logic [MW-1:0]        mag_a_r;
  logic [TW-1:0]        t_a_r;
  logic signed [AW-1:0] k_a_r;
  logic [AW-1:0]        acc_neg;
  logic [MW-1:0]        mag_nxt;

  assign acc_neg = ~acc_i + AW'(1);
  assign mag_nxt = acc_i[AW-1] ? acc_neg[MW-1:0] : acc_i[MW-1:0];

  // stage B: split products
  ctl_t                 ctl_b_r;
  logic                 neg_b_r;
  logic [PLW-1:0]       lo_b_r;
  logic [PHW-1:0]       hi_b_r;
  logic signed [AW-1:0] k_b_r;

  // stage C: round and add
  ctl_t                 ctl_c_r;
  logic signed [AW-1:0] acc_c_r;
  logic [PLW-1:0]       lo_rnd;
  logic [PHW-1:0]       q_sum;
  logic signed [AW-1:0] q_s;
  logic signed [AW-1:0] acc_nxt;

  assign lo_rnd  = lo_b_r + T_HALF;
  assign q_sum   = hi_b_r + PHW'(lo_rnd[PLW-1:TF]);
  assign q_s     = signed'(AW'(q_sum));
  assign acc_nxt = neg_b_r ? (k_b_r - q_s) : (k_b_r + q_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
    end else begin
      ctl_a_r <= ctl_i;
      ctl_b_r <= ctl_a_r;
      ctl_c_r <= ctl_b_r;
    end
  end

  always_ff @(posedge clk) begin
    neg_a_r <= acc_i[AW-1];
    mag_a_r <= mag_nxt;
    t_a_r   <= t_i;
    k_a_r   <= k_i;
    neg_b_r <= neg_a_r;
    lo_b_r  <= PLW'(mag_a_r[TF-1:0]) * PLW'(t_a_r);
    hi_b_r  <= PHW'(mag_a_r[MW-1:TF]) * PHW'(t_a_r);
    k_b_r   <= k_a_r;
    acc_c_r <= acc_nxt;
  end

  assign ctl_o = ctl_c_r;
  assign acc_o = acc_c_r;

endmodule

[rtl/cse_div3.sv]
// Pipelined divide by 3, one digit per stage from the top, passes x along.
// Depends on cse_pkg.
module cse_div3 import cse_pkg::*; #(
  parameter int XW = 37
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ctl_t          ctl_i,
  input  logic [XW-1:0] x_i,
  output ctl_t          ctl_o,
  output logic [XW-1:0] x_o,
  output logic [XW-1:0] quot_o
);

  localparam int ND  = (XW + DIGIT_W - 1) / DIGIT_W;
  localparam int XPW = ND * DIGIT_W;

  ctl_t             ctl_r  [ND];
  logic [XPW-1:0]   x_r    [ND];
  logic [XPW-1:0]   quot_r [ND];
  logic [REM_W-1:0] rem_r  [ND];

  for (genvar j = 0; j < ND; j++) begin : g_digit
    ctl_t             cs;
    logic [XPW-1:0]   xs;
    logic [XPW-1:0]   qs;
    logic [REM_W-1:0] rs;
    logic [DV_W-1:0]  v;
    logic [DPROD_W-1:0] prod;
    logic [DIGIT_W-1:0] qd;
    logic [DV_W-1:0]  q3;
    logic [DV_W-1:0]  rv;
    logic [XPW-1:0]   qn;

    if (j == 0) begin : g_first
      assign cs = ctl_i;
      assign xs = XPW'(x_i);
      assign qs = '0;
      assign rs = '0;
    end else begin : g_next
      assign cs = ctl_r[j-1];
      assign xs = x_r[j-1];
      assign qs = quot_r[j-1];
      assign rs = rem_r[j-1];
    end

    assign v    = {rs, xs[XPW-1-DIGIT_W*j -: DIGIT_W]};
    assign prod = DPROD_W'(v) * DPROD_W'(DIV3_RECIP);
    assign qd   = prod[DIV3_SHIFT +: DIGIT_W];
    assign q3   = {1'b0, qd, 1'b0} + {2'b00, qd};
    assign rv   = v - q3;

    always_comb begin
      qn = qs;
      qn[XPW-1-DIGIT_W*j -: DIGIT_W] = qd;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j] <= '0;
      end else begin
        ctl_r[j] <= cs;
      end
    end

    always_ff @(posedge clk) begin
      x_r[j]    <= xs;
      quot_r[j] <= qn;
      rem_r[j]  <= rv[REM_W-1:0];
    end
  end

  assign ctl_o  = ctl_r[ND-1];
  assign x_o    = x_r[ND-1][XW-1:0];
  assign quot_o = quot_r[ND-1][XW-1:0];

endmodule

[rtl/cubic_spline_segment_eval.sv]
// Top level of the cubic segment evaluator: basis register, coefficient stage,
// Horner chain, rounding divide and saturation. Depends on cse_pkg,
// cse_horner_step, cse_div3 and assert_macros.svh.
`include "assert_macros.svh"

// Evaluates p(t) = [t^3 t^2 t 1] * M * [a b c d] for one segment per item.
// busy is always low: an item may be started on every clock, and each
// result appears on out_curve_value / out_clipped for one cycle with
// out_valid, in start order. The receiver cannot hold a result off; it must
// take each one in the cycle it is shown. From start to out_valid an item
// passes one coefficient stage, three Horner steps of three stages each
// (magnitude, split multiply, round and add), one offset stage, the
// divide-by-3 digit pipeline (one 8-bit digit per stage) and the saturating
// output register. The basis register is sampled when an item starts; write
// it only while no item is in flight. Basis code 3 returns zero, unclipped.
module cubic_spline_segment_eval import cse_pkg::*; #(
  parameter int POINT_WIDTH = 32,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [POINT_WIDTH-1:0] in_point_a,
  input  logic signed [POINT_WIDTH-1:0] in_point_b,
  input  logic signed [POINT_WIDTH-1:0] in_point_c,
  input  logic signed [POINT_WIDTH-1:0] in_point_d,
  input  logic [T_FRAC_BITS:0]          in_param_t,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_wdata,
  output logic                          out_valid,
  output logic signed [POINT_WIDTH-1:0] out_curve_value,
  output logic                          out_clipped
);

  localparam int PW     = POINT_WIDTH;
  localparam int TF     = T_FRAC_BITS;
  localparam int TW     = TF + 1;
  localparam int MW_RAW = PW + 5;
  localparam int MW     = (MW_RAW > TF) ? MW_RAW : TF + 1;
  localparam int AW     = MW + 1;
  localparam int DLY_N  = 2 * STEP_LAT;
  localparam logic [TW-1:0] T_ONE = TW'(1) << TF;
  localparam logic signed [PW-1:0] PT_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] PT_MIN = {1'b1, {(PW-1){1'b0}}};
  localparam logic [MW-1:0] LIM_POS = MW'({1'b0, {(PW-1){1'b1}}});
  localparam logic [MW-1:0] LIM_NEG = MW'(1) << (PW - 1);

  assign busy = 1'b0;

  // configuration
  basis_t basis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      basis_r <= BASIS_BEZIER;
    end else if (cfg_we) begin
      basis_r <= basis_t'(cfg_wdata);
    end
  end

  // stage 1: polynomial coefficients and clamped t
  logic signed [AW-1:0] pa, pb, pc, pd;
  logic signed [AW-1:0] a3, b3, c3, b5, b6;
  logic signed [AW-1:0] k0_nxt, k1_nxt, k2_nxt, k3_nxt;
  logic [TW-1:0]        t_cl;

  assign pa = AW'(in_point_a);
  assign pb = AW'(in_point_b);
  assign pc = AW'(in_point_c);
  assign pd = AW'(in_point_d);
  assign a3 = (pa <<< 1) + pa;
  assign b3 = (pb <<< 1) + pb;
  assign c3 = (pc <<< 1) + pc;
  assign b5 = (pb <<< 2) + pb;
  assign b6 = b3 <<< 1;
  assign t_cl = (in_param_t[TF] && (|in_param_t[TF-1:0])) ? T_ONE : in_param_t;

  always_comb begin
    k0_nxt = b3 - pa - c3 + pd;
    case (basis_r)
      BASIS_BEZIER: begin
        k1_nxt = a3 - b6 + c3;
        k2_nxt = b3 - a3;
        k3_nxt = pa;
      end
      BASIS_BSPLINE: begin
        k1_nxt = a3 - b6 + c3;
        k2_nxt = c3 - a3;
        k3_nxt = pa + (pb <<< 2) + pc;
      end
      BASIS_CATMULL: begin
        k1_nxt = (pa <<< 1) - b5 + (pc <<< 2) - pd;
        k2_nxt = pc - pa;
        k3_nxt = pb <<< 1;
      end
      default: begin
        k0_nxt = '0;
        k1_nxt = '0;
        k2_nxt = '0;
        k3_nxt = '0;
      end
    endcase
  end

  ctl_t                 ctl1_r;
  logic signed [AW-1:0] k0_r, k1_r, k2_r, k3_r;
  logic [TW-1:0]        t1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r.valid <= start;
      ctl1_r.neg   <= 1'b0;
      ctl1_r.basis <= basis_r;
    end
  end

  always_ff @(posedge clk) begin
    k0_r <= k0_nxt;
    k1_r <= k1_nxt;
    k2_r <= k2_nxt;
    k3_r <= k3_nxt;
    t1_r <= t_cl;
  end

  // delay t and the later coefficients to meet their Horner step
  logic [TW-1:0]        t_dly_r  [DLY_N];
  logic signed [AW-1:0] k2_dly_r [STEP_LAT];
  logic signed [AW-1:0] k3_dly_r [DLY_N];

  always_ff @(posedge clk) begin
    t_dly_r[0]  <= t1_r;
    k2_dly_r[0] <= k2_r;
    k3_dly_r[0] <= k3_r;
    for (int i = 1; i < DLY_N; i++) begin
      t_dly_r[i]  <= t_dly_r[i-1];
      k3_dly_r[i] <= k3_dly_r[i-1];
    end
    for (int i = 1; i < STEP_LAT; i++) begin
      k2_dly_r[i] <= k2_dly_r[i-1];
    end
  end

  // Horner chain
  ctl_t                 ctl_h1, ctl_h2, ctl_h3;
  logic signed [AW-1:0] acc_h1, acc_h2, acc_h3;

  cse_horner_step #(.AW(AW), .TF(TF)) u_step1 (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl1_r),
    .acc_i (k0_r),
    .t_i   (t1_r),
    .k_i   (k1_r),
    .ctl_o (ctl_h1),
    .acc_o (acc_h1)
  );

  cse_horner_step #(.AW(AW), .TF(TF)) u_step2 (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_h1),
    .acc_i (acc_h1),
    .t_i   (t_dly_r[STEP_LAT-1]),
    .k_i   (k2_dly_r[STEP_LAT-1]),
    .ctl_o (ctl_h2),
    .acc_o (acc_h2)
  );

  cse_horner_step #(.AW(AW), .TF(TF)) u_step3 (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_h2),
    .acc_i (acc_h2),
    .t_i   (t_dly_r[DLY_N-1]),
    .k_i   (k3_dly_r[DLY_N-1]),
    .ctl_o (ctl_h3),
    .acc_o (acc_h3)
  );

  // offset stage: magnitude plus half the divisor, halved unless Bezier
  logic [1:0]    div_off;
  logic [AW-1:0] adj;
  logic [MW-1:0] x_nxt;
  ctl_t          ctl_d_r;
  logic [MW-1:0] x_d_r;

  always_comb begin
    case (ctl_h3.basis)
      BASIS_BSPLINE: div_off = 2'd3;
      BASIS_CATMULL: div_off = 2'd1;
      default:       div_off = 2'd0;
    endcase
  end

  assign adj   = acc_h3[AW-1] ? (~acc_h3 + AW'(div_off) + AW'(1)) : (acc_h3 + AW'(div_off));
  assign x_nxt = (ctl_h3.basis == BASIS_BEZIER) ? adj[MW-1:0] : {1'b0, adj[MW-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d_r <= '0;
    end else begin
      ctl_d_r.valid <= ctl_h3.valid;
      ctl_d_r.neg   <= acc_h3[AW-1];
      ctl_d_r.basis <= ctl_h3.basis;
    end
  end

  always_ff @(posedge clk) begin
    x_d_r <= x_nxt;
  end

  ctl_t          ctl_q;
  logic [MW-1:0] x_q;
  logic [MW-1:0] quot_q;

  cse_div3 #(.XW(MW)) u_div3 (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_d_r),
    .x_i    (x_d_r),
    .ctl_o  (ctl_q),
    .x_o    (x_q),
    .quot_o (quot_q)
  );

  // output stage: sign, saturate
  logic [MW-1:0]        mag_q;
  logic [PW-1:0]        mag_lo;
  logic                 q_basis_ok;
  logic                 clip_nxt;
  logic signed [PW-1:0] value_nxt;
  logic                 out_valid_r;
  logic signed [PW-1:0] out_value_r;
  logic                 out_clip_r;

  assign mag_q      = (ctl_q.basis == BASIS_BSPLINE) ? quot_q : x_q;
  assign mag_lo     = mag_q[PW-1:0];
  assign q_basis_ok = (ctl_q.basis == BASIS_BEZIER) || (ctl_q.basis == BASIS_BSPLINE) ||
                      (ctl_q.basis == BASIS_CATMULL);

  always_comb begin
    if (!q_basis_ok) begin
      clip_nxt  = 1'b0;
      value_nxt = '0;
    end else if (ctl_q.neg) begin
      clip_nxt  = (mag_q > LIM_NEG);
      value_nxt = clip_nxt ? PT_MIN : signed'(~mag_lo + PW'(1));
    end else begin
      clip_nxt  = (mag_q > LIM_POS);
      value_nxt = clip_nxt ? PT_MAX : signed'(mag_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_q.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= value_nxt;
    out_clip_r  <= clip_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_curve_value = out_value_r;
  assign out_clipped     = out_clip_r;

  logic q_bad_basis;
  logic q_good_basis;
  logic out_at_limit;
  logic out_is_zero;
  logic out_neg;

  assign q_bad_basis  = ctl_q.valid && !q_basis_ok;
  assign q_good_basis = ctl_q.valid && q_basis_ok;
  assign out_at_limit = (out_curve_value == PT_MAX) || (out_curve_value == PT_MIN);
  assign out_is_zero  = (out_curve_value == '0);
  assign out_neg      = out_curve_value[PW-1];

  `CSE_ASSERT(a_clip_at_limit, out_valid && out_clipped |-> out_at_limit, "clip off limit")
  `CSE_ASSERT_NEXT(a_bad_basis, q_bad_basis, out_is_zero && !out_clipped, "unused basis not zero")
  `CSE_ASSERT_NEXT(a_sign, q_good_basis, out_neg == $past(ctl_q.neg) || out_is_zero, "sign lost")

endmodule
